@@ sv/wsfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared types and constants of the websocket frame receiver: parser phases,
// event codes, opcodes, header length codes and the queue word layout.
// ----------------------------------------------------------------------------
package wsfr_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_MASK  = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    // result event codes
    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_PING  = 2'd1,
        EV_CLOSE = 2'd2
    } event_t;

    // frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    // seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // byte count of the last byte in each multi-byte header part
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] MASK_LAST  = 3'd3;

    // word passed from the parser to the output stage
    typedef struct packed {
        event_t      event_res;
        logic        has_byte;
        logic [7:0]  raw_byte;
        logic [7:0]  key_byte;
        logic        last;
        logic [63:0] frame_length;
    } item_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage
`default_nettype wire

@@ sv/wsfr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_if
// Valid/ready channels of the websocket frame receiver: the received byte
// stream and the result event stream.
// ----------------------------------------------------------------------------
interface wsfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_event_if;
    logic                valid;
    logic                ready;
    wsfr_pkg::event_t    event_res;
    logic                has_byte;
    logic [7:0]          payload_byte;
    logic                last;
    logic [63:0]         frame_length;

    modport source (output valid, output event_res, output has_byte, output payload_byte,
                    output last, output frame_length, input ready);
    modport sink   (input valid, input event_res, input has_byte, input payload_byte,
                    input last, input frame_length, output ready);
endinterface
`default_nettype wire

@@ sv/wsfr_parse.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_parse
// Front end: one byte per cycle unless the queue is full; walks the frame
// header, tracks the payload position, pushes one word per result to the queue.
// ----------------------------------------------------------------------------
module wsfr_parse (
    input  logic             clk,
    input  logic             rst_n,
    wsfr_byte_if.sink        rx,
    input  wsfr_pkg::qstat_t qstat,
    output logic             push,
    output wsfr_pkg::item_t  push_item
);
    import wsfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    logic        mask_reg, mask_next;
    logic [63:0] len_reg, len_next;
    logic [2:0]  hcnt_reg, hcnt_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] rem_reg, rem_next;
    logic [1:0]  idx_reg, idx_next;

    logic        accept;
    logic [7:0]  b;
    logic [6:0]  len7;
    logic        is_ext16, is_ext64;
    logic        in_ext;
    logic [2:0]  ext_last;
    logic        len_done, mask_now, hdr_done, len_zero, data_end, is_data_op;

    // handshake: only a full queue holds the byte stream
    assign rx.ready = !qstat.full;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    // header decode
    assign len7       = b[6:0];
    assign is_ext16   = (len7 == LEN_EXT16);
    assign is_ext64   = (len7 == LEN_EXT64);
    assign in_ext     = (phase_reg == PH_EXT16) || (phase_reg == PH_EXT64);
    assign ext_last   = (phase_reg == PH_EXT16) ? EXT16_LAST : EXT64_LAST;
    assign len_done   = ((phase_reg == PH_HDR1) && !is_ext16 && !is_ext64)
                        || (in_ext && (hcnt_reg == ext_last));
    assign mask_now   = (phase_reg == PH_HDR1) ? b[7] : mask_reg;
    assign hdr_done   = (len_done && !mask_now)
                        || ((phase_reg == PH_MASK) && (hcnt_reg >= MASK_LAST));
    assign len_zero   = (len_next == 64'd0);
    assign data_end   = (rem_reg == 64'd1);
    assign is_data_op = (op_reg == OP_CONT) || (op_reg == OP_TEXT) || (op_reg == OP_BINARY);

    // header fields and payload counters
    always_comb
    begin
        fin_next  = fin_reg;
        op_next   = op_reg;
        mask_next = mask_reg;
        len_next  = len_reg;
        hcnt_next = hcnt_reg;
        key_next  = key_reg;
        rem_next  = rem_reg;
        idx_next  = idx_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    mask_next = b[7];
                    hcnt_next = 3'd0;
                    len_next  = (is_ext16 || is_ext64) ? 64'd0 : {57'd0, len7};
                end
                PH_EXT16, PH_EXT64:
                begin
                    len_next  = {len_reg[55:0], b};
                    hcnt_next = len_done ? 3'd0 : hcnt_reg + 3'd1;
                end
                PH_MASK:
                begin
                    key_next  = {key_reg[23:0], b};
                    hcnt_next = hdr_done ? 3'd0 : hcnt_reg + 3'd1;
                end
                PH_DATA:
                begin
                    rem_next = rem_reg - 64'd1;
                    idx_next = idx_reg + 2'd1;
                end
                default:
                begin
                    fin_next = b[7];
                    op_next  = b[3:0];
                end
            endcase
            // key restarts once the length is known
            if (len_done)
            begin
                key_next = 32'd0;
            end
            // header complete: arm the payload counters
            if (hdr_done)
            begin
                rem_next  = len_next;
                idx_next  = 2'd0;
                hcnt_next = 3'd0;
            end
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    if (is_ext16)
                    begin
                        phase_next = PH_EXT16;
                    end
                    else if (is_ext64)
                    begin
                        phase_next = PH_EXT64;
                    end
                end
                PH_EXT16, PH_EXT64, PH_MASK:
                begin
                    phase_next = phase_reg;
                end
                PH_DATA:
                begin
                    if (data_end)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR1;
                end
            endcase
            if (len_done && mask_now)
            begin
                phase_next = PH_MASK;
            end
            if (hdr_done)
            begin
                phase_next = len_zero ? PH_HDR0 : PH_DATA;
            end
        end
    end

    // result words
    always_comb
    begin
        push                   = 1'b0;
        push_item.event_res    = EV_DATA;
        push_item.has_byte     = 1'b0;
        push_item.raw_byte     = 8'd0;
        push_item.key_byte     = 8'd0;
        push_item.last         = 1'b0;
        push_item.frame_length = len_next;
        if (accept)
        begin
            if (phase_reg == PH_DATA)
            begin
                if (is_data_op || (op_reg == OP_PING))
                begin
                    push                = 1'b1;
                    push_item.has_byte  = 1'b1;
                    push_item.raw_byte  = b;
                    push_item.key_byte  = mask_reg ? key_reg[{~idx_reg, 3'b000} +: 8] : 8'd0;
                    if (is_data_op)
                    begin
                        push_item.last = data_end && fin_reg;
                    end
                    else
                    begin
                        push_item.event_res = EV_PING;
                        push_item.last      = data_end;
                    end
                end
                else if ((op_reg == OP_CLOSE) && data_end)
                begin
                    push                = 1'b1;
                    push_item.event_res = EV_CLOSE;
                end
            end
            else if (hdr_done && len_zero)
            begin
                // empty frames finish on the last header byte
                if (is_data_op)
                begin
                    push           = fin_reg;
                    push_item.last = 1'b1;
                end
                else if (op_reg == OP_PING)
                begin
                    push                = 1'b1;
                    push_item.event_res = EV_PING;
                    push_item.last      = 1'b1;
                end
                else if (op_reg == OP_CLOSE)
                begin
                    push                = 1'b1;
                    push_item.event_res = EV_CLOSE;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            fin_reg   <= 1'b0;
            op_reg    <= 4'd0;
            mask_reg  <= 1'b0;
            len_reg   <= 64'd0;
            hcnt_reg  <= 3'd0;
            key_reg   <= 32'd0;
            rem_reg   <= 64'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            fin_reg   <= fin_next;
            op_reg    <= op_next;
            mask_reg  <= mask_next;
            len_reg   <= len_next;
            hcnt_reg  <= hcnt_next;
            key_reg   <= key_next;
            rem_reg   <= rem_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/wsfr_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_queue
// Small first-in first-out queue of result words between the parser and the
// output stage.
// ----------------------------------------------------------------------------
module wsfr_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wsfr_pkg::item_t  push_item,
    input  logic             pop,
    output wsfr_pkg::item_t  pop_item,
    output wsfr_pkg::qstat_t qstat
);
    import wsfr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign pop_item    = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CW'(DEPTH));
    assign qstat.empty = (count_reg == '0);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/wsfr_emit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_emit
// Back end: pops result words, unmasks the payload byte and holds the result
// in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module wsfr_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  wsfr_pkg::item_t  pop_item,
    input  wsfr_pkg::qstat_t qstat,
    output logic             pop,
    wsfr_event_if.source     evt
);
    import wsfr_pkg::*;

    logic        valid_reg, valid_next;
    event_t      ev_reg;
    logic        has_reg;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg;
    logic [63:0] len_reg;

    // refill the output register when it is empty or being taken
    assign pop        = !qstat.empty && (!valid_reg || evt.ready);
    assign valid_next = pop || (valid_reg && !evt.ready);
    assign byte_next  = pop_item.has_byte ? (pop_item.raw_byte ^ pop_item.key_byte) : 8'd0;

    assign evt.valid        = valid_reg;
    assign evt.event_res    = ev_reg;
    assign evt.has_byte     = has_reg;
    assign evt.payload_byte = byte_reg;
    assign evt.last         = last_reg;
    assign evt.frame_length = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg   <= pop_item.event_res;
            has_reg  <= pop_item.has_byte;
            byte_reg <= byte_next;
            last_reg <= pop_item.last;
            len_reg  <= pop_item.frame_length;
        end
    end

endmodule
`default_nettype wire

@@ sv/websocket_frame_receiver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Receive-side frame parser: header decode, payload unmasking and event output.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while rx.ready is high
// and gives at most one result word per byte, held first in the result queue
// and then in the output register. The header parser handles every byte as
// it arrives, so rx.ready falls only while the QUEUE_DEPTH-entry result queue
// is full, which happens only once QUEUE_DEPTH + 1 results wait on a stalled
// event sink (the queue entries plus the output register).
// Data, ping and close events follow the stream order; pong and unknown
// opcodes are consumed with no result.
module websocket_frame_receiver #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    wsfr_byte_if.sink    rx,
    wsfr_event_if.source evt
);
    import wsfr_pkg::*;

    logic   push, pop;
    item_t  push_item, pop_item;
    qstat_t qstat;

    // header parser
    wsfr_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    // result queue
    wsfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    // unmask and output register
    wsfr_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_item (pop_item),
        .qstat    (qstat),
        .pop      (pop),
        .evt      (evt)
    );

endmodule
`default_nettype wire

@@ sv/wsfr_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_checker
// Port-level checks of the websocket frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module wsfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  event_res,
    input logic        has_byte,
    input logic [7:0]  payload_byte,
    input logic        last,
    input logic [63:0] frame_length
);
    import wsfr_pkg::*;

    // stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(has_byte)
            && $stable(payload_byte) && $stable(last) && $stable(frame_length))
        else $error("result word changed while stalled");

    // no byte means a zero byte
    a_empty_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> payload_byte == 8'd0)
        else $error("payload byte set without has_byte");

    // close event carries no byte and no last
    a_close_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_CLOSE) |-> !has_byte && !last)
        else $error("close event malformed");

    // byteless data word is an empty final frame
    a_empty_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_DATA) && !has_byte |-> last && (frame_length == 64'd0))
        else $error("byteless data word is not an empty final frame");

    // byteless ping word is an empty ping
    a_empty_ping: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_PING) && !has_byte |-> last && (frame_length == 64'd0))
        else $error("byteless ping word is not an empty ping");

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (evt.valid),
    .out_ready    (evt.ready),
    .event_res    (evt.event_res),
    .has_byte     (evt.has_byte),
    .payload_byte (evt.payload_byte),
    .last         (evt.last),
    .frame_length (evt.frame_length)
);
`default_nettype wire
